### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check is sampled on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define LLI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lli: assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define LLI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lli: implication failed");

`endif

### rtl/lli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_pkg
// Shared constants and register codes for the line intersection block.
// ----------------------------------------------------------------------------
package lli_pkg;

  // Output coordinate format: signed Q16.16
  localparam int unsigned OUT_WIDTH = 32;
  localparam int unsigned OUT_FRAC  = 16;

  // Configuration register layout
  localparam int unsigned THR_WIDTH  = 16;
  localparam int unsigned ADDR_WIDTH = 3;
  localparam int unsigned DATA_WIDTH = 32;

  typedef enum logic {
    REG_THRESHOLD = 1'b0
  } reg_idx_e;

endpackage

### rtl/lli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_div
// Pipelined restoring divider: one quotient bit per stage, NUM_WIDTH stages.
// Unsigned operands; a sideband word travels alongside each beat.
// ----------------------------------------------------------------------------
module lli_div #(
  parameter int unsigned NUM_WIDTH  = 59,
  parameter int unsigned DEN_WIDTH  = 35,
  parameter int unsigned META_WIDTH = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [NUM_WIDTH-1:0]  num_i,
  input  logic [DEN_WIDTH-1:0]  den_i,
  input  logic [META_WIDTH-1:0] meta_i,
  output logic                  valid_o,
  output logic [NUM_WIDTH-1:0]  quo_o,
  output logic [META_WIDTH-1:0] meta_o
);

  logic                  vld_q  [NUM_WIDTH];
  logic [DEN_WIDTH-1:0]  rem_q  [NUM_WIDTH];
  logic [DEN_WIDTH-1:0]  den_q  [NUM_WIDTH];
  logic [NUM_WIDTH-1:0]  num_q  [NUM_WIDTH];
  logic [NUM_WIDTH-1:0]  quo_q  [NUM_WIDTH];
  logic [META_WIDTH-1:0] meta_q [NUM_WIDTH];

  for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
    logic                  vld_in;
    logic [DEN_WIDTH-1:0]  rem_in;
    logic [DEN_WIDTH-1:0]  den_in;
    logic [NUM_WIDTH-1:0]  num_in;
    logic [NUM_WIDTH-1:0]  quo_in;
    logic [META_WIDTH-1:0] meta_in;
    logic [DEN_WIDTH:0]    rem_sh;
    logic [DEN_WIDTH+1:0]  diff;
    logic                  ge;

    // Pick the beat coming from the port or from the stage before
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign num_in  = num_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign meta_in = meta_q[s-1];
    end

    // Shift in the next numerator bit and try the subtract
    assign rem_sh = {rem_in, num_in[NUM_WIDTH-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_in};
    assign ge     = ~diff[DEN_WIDTH+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
      den_q[s]  <= den_in;
      num_q[s]  <= num_in << 1;
      quo_q[s]  <= {quo_in[NUM_WIDTH-2:0], ge};
      meta_q[s] <= meta_in;
    end
  end

  assign valid_o = vld_q[NUM_WIDTH-1];
  assign quo_o   = quo_q[NUM_WIDTH-1];
  assign meta_o  = meta_q[NUM_WIDTH-1];

endmodule

### rtl/line_line_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_line_intersection
// Intersection of two lines by Cramer's rule, signed Q16.16 result.
// ----------------------------------------------------------------------------
// Pulse start with eight endpoint coordinates; busy stays low, so a new pair
// of lines is taken on every cycle. Each pair gives one result, marked by a
// one-cycle done_o strobe, after the coefficient, C, determinant, numerator,
// N divider and output register stages, where N = 3*COORD_WIDTH + 3 + 16 -
// FRAC_BITS is the bit-per-stage divider depth (59 stages by default). The
// receiver cannot hold results off. Lines whose determinant magnitude is
// zero or below the threshold register come back with is_parallel_o set and
// zero coordinates; otherwise the quotient is truncated toward zero and
// clipped to 32 bits, with saturated_o flagging a clip. Write the threshold
// only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_line_intersection #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command side
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      line1_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]      line1_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]      line1_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]      line1_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]      line2_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]      line2_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]      line2_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]      line2_end_y_i,
  // Result side
  output logic                               done_o,
  output logic signed [lli_pkg::OUT_WIDTH-1:0] cross_x_o,
  output logic signed [lli_pkg::OUT_WIDTH-1:0] cross_y_o,
  output logic                               is_parallel_o,
  output logic                               saturated_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lli_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [lli_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [lli_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                               pready
);

  import lli_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned AW   = W + 1;          // A, B
  localparam int unsigned PW   = 2 * W;          // coordinate products
  localparam int unsigned CW   = 2 * W + 1;      // C
  localparam int unsigned DPW  = 2 * W + 2;      // determinant products
  localparam int unsigned DW   = 2 * W + 3;      // determinant
  localparam int unsigned NPW  = 3 * W + 2;      // numerator products
  localparam int unsigned NXW  = 3 * W + 3;      // numerators
  localparam int unsigned SH   = OUT_FRAC - FRAC_BITS;
  localparam int unsigned NW   = NXW + SH;       // scaled numerator
  localparam int unsigned QW   = (NW > OUT_WIDTH + 1) ? NW : OUT_WIDTH + 1;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [THR_WIDTH-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_WIDTH'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      thr_q <= pwdata[THR_WIDTH-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? DATA_WIDTH'(thr_q) : '0;

  // Every cycle takes a beat
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: line coefficients A, B and the products for C
  // --------------------------------------------------------------------------
  logic                 v1_q;
  logic signed [AW-1:0] a1_s1_q, b1_s1_q, a2_s1_q, b2_s1_q;
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_s1_q <= AW'(line1_start_y_i) - AW'(line1_end_y_i);
    b1_s1_q <= AW'(line1_end_x_i) - AW'(line1_start_x_i);
    a2_s1_q <= AW'(line2_start_y_i) - AW'(line2_end_y_i);
    b2_s1_q <= AW'(line2_end_x_i) - AW'(line2_start_x_i);
    p1a_q   <= PW'(line1_start_x_i) * PW'(line1_end_y_i);
    p1b_q   <= PW'(line1_end_x_i) * PW'(line1_start_y_i);
    p2a_q   <= PW'(line2_start_x_i) * PW'(line2_end_y_i);
    p2b_q   <= PW'(line2_end_x_i) * PW'(line2_start_y_i);
  end

  // --------------------------------------------------------------------------
  // Stage 2: C terms and the determinant products
  // --------------------------------------------------------------------------
  logic                  v2_q;
  logic signed [AW-1:0]  a1_s2_q, b1_s2_q, a2_s2_q, b2_s2_q;
  logic signed [CW-1:0]  c1_q, c2_q;
  logic signed [DPW-1:0] dpa_q, dpb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_s2_q <= a1_s1_q;
    b1_s2_q <= b1_s1_q;
    a2_s2_q <= a2_s1_q;
    b2_s2_q <= b2_s1_q;
    c1_q    <= CW'(p1a_q) - CW'(p1b_q);
    c2_q    <= CW'(p2a_q) - CW'(p2b_q);
    dpa_q   <= DPW'(a1_s1_q) * DPW'(b2_s1_q);
    dpb_q   <= DPW'(b1_s1_q) * DPW'(a2_s1_q);
  end

  // --------------------------------------------------------------------------
  // Stage 3: determinant and numerator products
  // --------------------------------------------------------------------------
  logic                  v3_q;
  logic signed [DW-1:0]  det_s3_q;
  logic signed [NPW-1:0] bc2_q, b2c1_q, a2c1_q, a1c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    det_s3_q <= DW'(dpa_q) - DW'(dpb_q);
    bc2_q    <= NPW'(b1_s2_q) * NPW'(c2_q);
    b2c1_q   <= NPW'(b2_s2_q) * NPW'(c1_q);
    a2c1_q   <= NPW'(a2_s2_q) * NPW'(c1_q);
    a1c2_q   <= NPW'(a1_s2_q) * NPW'(c2_q);
  end

  // --------------------------------------------------------------------------
  // Stage 4: numerators
  // --------------------------------------------------------------------------
  logic                  v4_q;
  logic signed [DW-1:0]  det_q;
  logic signed [NXW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    det_q <= det_s3_q;
    nx_q  <= NXW'(bc2_q) - NXW'(b2c1_q);
    ny_q  <= NXW'(a2c1_q) - NXW'(a1c2_q);
  end

  // --------------------------------------------------------------------------
  // Magnitudes, signs and the parallel test, into the dividers
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] nxs, nys;
  logic [NW-1:0]        numx, numy;
  logic [DW-1:0]        den;
  logic                 neg_x, neg_y, par;

  always_comb begin
    nxs   = NW'(nx_q) <<< SH;
    nys   = NW'(ny_q) <<< SH;
    neg_x = nxs[NW-1] ^ det_q[DW-1];
    neg_y = nys[NW-1] ^ det_q[DW-1];
    numx  = nxs[NW-1] ? NW'(-nxs) : NW'(nxs);
    numy  = nys[NW-1] ? NW'(-nys) : NW'(nys);
    den   = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    par   = (den == '0) || (den < DW'(thr_q));
  end

  logic             vld_x, vld_y;
  logic [NW-1:0]    quo_x, quo_y;
  logic [1:0]       meta_x;
  logic             meta_y;

  lli_div #(
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (DW),
    .META_WIDTH (2)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (numx),
    .den_i   (den),
    .meta_i  ({par, neg_x}),
    .valid_o (vld_x),
    .quo_o   (quo_x),
    .meta_o  (meta_x)
  );

  lli_div #(
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (DW),
    .META_WIDTH (1)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (numy),
    .den_i   (den),
    .meta_i  (neg_y),
    .valid_o (vld_y),
    .quo_o   (quo_y),
    .meta_o  (meta_y)
  );

  // --------------------------------------------------------------------------
  // Clip to signed 32 bits and register the result beat
  // --------------------------------------------------------------------------
  logic [QW-1:0]        qx, qy, lim_x, lim_y;
  logic                 ovf_x, ovf_y;
  logic [OUT_WIDTH-1:0] mag_x, mag_y;

  always_comb begin
    qx    = QW'(quo_x);
    qy    = QW'(quo_y);
    lim_x = meta_x[0] ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
    lim_y = meta_y    ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
    ovf_x = qx > lim_x;
    ovf_y = qy > lim_y;
    mag_x = ovf_x ? lim_x[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0];
    mag_y = ovf_y ? lim_y[OUT_WIDTH-1:0] : qy[OUT_WIDTH-1:0];
  end

  logic                        done_q;
  logic signed [OUT_WIDTH-1:0] cross_x_q, cross_y_q;
  logic                        par_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_x && vld_y;
    end
  end

  always_ff @(posedge clk_i) begin
    par_q <= meta_x[1];
    if (meta_x[1]) begin
      cross_x_q <= '0;
      cross_y_q <= '0;
      sat_q     <= 1'b0;
    end else begin
      cross_x_q <= meta_x[0] ? -mag_x : mag_x;
      cross_y_q <= meta_y    ? -mag_y : mag_y;
      sat_q     <= ovf_x || ovf_y;
    end
  end

  assign done_o        = done_q;
  assign cross_x_o     = cross_x_q;
  assign cross_y_o     = cross_y_q;
  assign is_parallel_o = par_q;
  assign saturated_o   = sat_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `LLI_ASSERT(a_div_lockstep, vld_x == vld_y)
  `LLI_ASSERT_IMP(a_par_zero, done_o && is_parallel_o, cross_x_o == '0 && cross_y_o == '0)
  `LLI_ASSERT_IMP(a_par_nosat, done_o && is_parallel_o, !saturated_o)

endmodule
